/* hdl/word_wrap_line_indexer_assert.svh */
// Assertion macros shared by the line indexer checker.
`ifndef WORD_WRAP_LINE_INDEXER_ASSERT_SVH
`define WORD_WRAP_LINE_INDEXER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WWLI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word_wrap_line_indexer assertion failed");

// Next-cycle implication, disabled during reset.
`define WWLI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word_wrap_line_indexer assertion failed");

`endif

/* hdl/wwli_pkg.sv */
// Package with the shared types and constants of the line indexer.
package wwli_pkg;

  localparam int MAX_LINES   = 4096;
  localparam int LINE_W      = 13;
  localparam int IDX_W       = 12;
  localparam int OFFSET_W    = 32;
  localparam int COLUMN_W    = 16;
  localparam int WIDTH_W     = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic REQ_START = 1'b0;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_BLANK,
    KIND_LF,
    KIND_CR,
    KIND_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    PART_NONE,
    PART_LF,
    PART_CR
  } partner_t;

  typedef struct packed {
    kind_t kind;
  } item_t;

endpackage

/* hdl/wwli_front.sv */
// Front part: accepts requests and classifies each text byte.
module wwli_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // text_byte
  input  logic [0:0]         s_tuser,   // req_type
  output logic               push_valid,
  input  logic               push_ready,
  output wwli_pkg::item_t    push_item
);

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;

  always_comb begin
    if (s_tuser[0] == wwli_pkg::REQ_START) begin
      push_item.kind = wwli_pkg::KIND_START;
    end else begin
      unique case (s_tdata) inside
        wwli_pkg::CHAR_TAB, wwli_pkg::CHAR_SPACE: push_item.kind = wwli_pkg::KIND_BLANK;
        wwli_pkg::CHAR_LF:                        push_item.kind = wwli_pkg::KIND_LF;
        wwli_pkg::CHAR_CR:                        push_item.kind = wwli_pkg::KIND_CR;
        default:                                  push_item.kind = wwli_pkg::KIND_OTHER;
      endcase
    end
  end

endmodule

/* hdl/wwli_queue.sv */
// Short queue of classified requests between the front and back parts.
module wwli_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  wwli_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wwli_pkg::item_t pop_item
);

  wwli_pkg::item_t                 mem [wwli_pkg::QUEUE_DEPTH];
  logic [wwli_pkg::QPTR_W-1:0]     wr_ptr;
  logic [wwli_pkg::QPTR_W-1:0]     rd_ptr;
  logic [wwli_pkg::QCNT_W-1:0]     count;
  logic                            push;
  logic                            pop;

  assign push_ready = (count != wwli_pkg::QCNT_W'(wwli_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/wwli_back.sv */
// Back part: line state update and the registered result output.
module wwli_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wwli_pkg::WIDTH_W-1:0]  wrap_width,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  wwli_pkg::item_t               pop_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,
  output logic [0:0]                    m_tuser
);

  logic [wwli_pkg::OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic [wwli_pkg::LINE_W-1:0]   lines_used, lines_used_next;
  logic                          in_blank_run, in_blank_run_next;
  logic                          prev_blank, prev_blank_next;
  wwli_pkg::partner_t            partner, partner_next;
  logic [wwli_pkg::COLUMN_W-1:0] column, column_next;
  logic [wwli_pkg::COLUMN_W-1:0] break_column, break_column_next;
  logic [wwli_pkg::OFFSET_W-1:0] break_offset, break_offset_next;

  logic [wwli_pkg::IDX_W-1:0]    res_index, out_index;
  logic [wwli_pkg::OFFSET_W-1:0] res_offset, out_offset;
  logic                          res_rewrite, out_rewrite;
  logic [wwli_pkg::LINE_W-1:0]   res_count, out_count;
  logic                          res_valid;

  logic                          pop;
  logic [wwli_pkg::OFFSET_W-1:0] off;
  logic [wwli_pkg::COLUMN_W-1:0] col1;
  logic [wwli_pkg::COLUMN_W-1:0] bc;
  logic [wwli_pkg::OFFSET_W-1:0] bo;
  logic                          blank;
  logic                          ends_line;
  logic                          wraps;
  logic                          partner_hit;
  logic                          active;

  assign pop_ready = !m_tvalid || m_tready;
  assign pop       = pop_valid && pop_ready;
  assign blank     = (pop_item.kind == wwli_pkg::KIND_BLANK);
  assign ends_line = (pop_item.kind == wwli_pkg::KIND_LF) || (pop_item.kind == wwli_pkg::KIND_CR);
  assign active    = (lines_used != '0) &&
                     (lines_used < wwli_pkg::LINE_W'(wwli_pkg::MAX_LINES));
  assign off       = byte_offset + 1'b1;
  assign col1      = (column != '1) ? column + 1'b1 : column;
  assign wraps     = !blank && (wrap_width != '0) &&
                     (col1 > {{(wwli_pkg::COLUMN_W-wwli_pkg::WIDTH_W){1'b0}}, wrap_width});
  assign partner_hit = ((partner == wwli_pkg::PART_LF) && (pop_item.kind == wwli_pkg::KIND_LF)) ||
                       ((partner == wwli_pkg::PART_CR) && (pop_item.kind == wwli_pkg::KIND_CR));

  always_comb begin
    byte_offset_next  = byte_offset;
    lines_used_next   = lines_used;
    in_blank_run_next = in_blank_run;
    prev_blank_next   = prev_blank;
    partner_next      = partner;
    column_next       = column;
    break_column_next = break_column;
    break_offset_next = break_offset;
    res_valid         = 1'b0;
    res_index         = lines_used[wwli_pkg::IDX_W-1:0];
    res_offset        = '0;
    res_rewrite       = 1'b0;
    res_count         = lines_used;
    bc                = break_column;
    bo                = break_offset;
    if (pop) begin
      if (pop_item.kind == wwli_pkg::KIND_START) begin
        byte_offset_next  = '0;
        lines_used_next   = wwli_pkg::LINE_W'(1);
        in_blank_run_next = 1'b0;
        prev_blank_next   = 1'b0;
        partner_next      = wwli_pkg::PART_NONE;
        column_next       = '0;
        break_column_next = '0;
        break_offset_next = '0;
        res_valid         = 1'b1;
        res_index         = '0;
        res_offset        = '0;
        res_count         = wwli_pkg::LINE_W'(1);
      end else if (active) begin
        byte_offset_next = off;
        partner_next     = wwli_pkg::PART_NONE;
        if (partner_hit) begin
          break_offset_next = '0;
          res_valid         = 1'b1;
          res_index         = wwli_pkg::IDX_W'(lines_used - 1'b1);
          res_offset        = off;
          res_rewrite       = 1'b1;
        end else if (!(blank && in_blank_run)) begin
          if (!blank && prev_blank) begin
            bc = col1 - 1'b1;
            bo = off - 1'b1;
          end
          if (ends_line || wraps) begin
            if (ends_line) begin
              partner_next = (pop_item.kind == wwli_pkg::KIND_CR) ? wwli_pkg::PART_LF
                                                                  : wwli_pkg::PART_CR;
              bc = col1;
              bo = off;
            end else if (bo == '0) begin
              bc = col1 - 1'b1;
              bo = off - 1'b1;
            end
            res_valid         = 1'b1;
            res_offset        = bo;
            res_count         = lines_used + 1'b1;
            lines_used_next   = lines_used + 1'b1;
            in_blank_run_next = 1'b0;
            prev_blank_next   = 1'b0;
            column_next       = (bc > col1) ? '0 : col1 - bc;
            break_column_next = '0;
            break_offset_next = '0;
          end else begin
            in_blank_run_next = blank;
            prev_blank_next   = blank;
            column_next       = col1;
            break_column_next = bc;
            break_offset_next = bo;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      lines_used   <= '0;
      in_blank_run <= 1'b0;
      prev_blank   <= 1'b0;
      partner      <= wwli_pkg::PART_NONE;
      column       <= '0;
      break_column <= '0;
      break_offset <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      byte_offset  <= byte_offset_next;
      lines_used   <= lines_used_next;
      in_blank_run <= in_blank_run_next;
      prev_blank   <= prev_blank_next;
      partner      <= partner_next;
      column       <= column_next;
      break_column <= break_column_next;
      break_offset <= break_offset_next;
      if (pop && res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_index   <= res_index;
      out_offset  <= res_offset;
      out_rewrite <= res_rewrite;
      out_count   <= res_count;
    end
  end

  assign m_tdata = {6'd0,
                    (out_count >= wwli_pkg::LINE_W'(wwli_pkg::MAX_LINES)),
                    out_count, out_offset, out_index};
  assign m_tuser = out_rewrite;

endmodule

/* hdl/word_wrap_line_indexer.sv */
// Top level of the word wrap line indexer.
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  tdata: text_byte; tuser: req_type
//   m_*       out        m_tvalid / m_tready  tdata: line table entry; tuser: is_rewrite
//   wrap_*    in         wrap_width_we        wrap_width
// One request is taken per cycle while the queue has room, and one result per cycle.
// A result is registered as its request leaves the queue and shows in the next cycle;
// the state update in the back part sets the rate.
// Reset is synchronous and clears the line state, the queue and the output valid.
// A stalled output holds its result; the two-entry queue absorbs requests meanwhile.
module word_wrap_line_indexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        wrap_width_we,
  input  logic [7:0]  wrap_width_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [11:0] entry_index, [43:12] entry_offset,
                                 // [56:44] line_count, [57] table_full, rest zero
  output logic [0:0]  m_tuser    // [0] is_rewrite
);

  logic [wwli_pkg::WIDTH_W-1:0] wrap_width;
  logic                         push_valid;
  logic                         push_ready;
  wwli_pkg::item_t              push_item;
  logic                         pop_valid;
  logic                         pop_ready;
  wwli_pkg::item_t              pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= '0;
    end else if (wrap_width_we) begin
      wrap_width <= wrap_width_wdata;
    end
  end

  wwli_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  wwli_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  wwli_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wrap_width (wrap_width),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

/* hdl/wwli_checker.sv */
// Port-level checker for the line indexer and its bind to the top level.
`include "word_wrap_line_indexer_assert.svh"

module wwli_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `WWLI_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `WWLI_ASSERT_IMP(a_index_count, clk, rst, m_tvalid, (m_tdata[11:0] + 12'd1) == m_tdata[55:44])
  `WWLI_ASSERT_IMP(a_full_flag, clk, rst, m_tvalid, m_tdata[57] == m_tdata[56])
  `WWLI_ASSERT_IMP(a_first_line, clk, rst, m_tvalid && !m_tuser[0] && (m_tdata[56:44] == 13'd1), m_tdata[43:12] == 32'd0)

endmodule

bind word_wrap_line_indexer wwli_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
// Self-checking testbench for the word wrap line indexer.
`timescale 1ns / 1ps

module tb_top;

  localparam logic REQ_TEXT = 1'b1;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [11:0] index;
    logic [31:0] offset;
    logic        rewrite;
    logic [12:0] count;
    logic        full;
  } line_entry_t;

  logic        clk;
  logic        rst;
  logic        wrap_width_we;
  logic [7:0]  wrap_width_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  // Predicted line table state.
  logic [7:0]  width_reg;
  logic [31:0] text_offset;
  int          lines_in_table;
  bit          blank_run;
  bit          last_blank;
  logic [7:0]  awaited_partner;
  int          cur_column;
  int          cand_column;
  logic [31:0] cand_offset;

  line_entry_t pending_entries[$];
  line_entry_t want;
  int          errors;
  int          requests_sent;
  int          entries_checked;
  bit          idling;

  word_wrap_line_indexer DUT (
    .clk              (clk),
    .rst              (rst),
    .wrap_width_we    (wrap_width_we),
    .wrap_width_wdata (wrap_width_wdata),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic line_entry_t make_entry(input int idx, input logic [31:0] offset,
                                             input bit rewrite);
    line_entry_t e;
    e.index   = idx[11:0];
    e.offset  = offset;
    e.rewrite = rewrite;
    e.count   = lines_in_table[12:0];
    e.full    = (lines_in_table >= wwli_pkg::MAX_LINES);
    return e;
  endfunction

  function automatic void clear_lines();
    text_offset     = '0;
    lines_in_table  = 0;
    blank_run       = 0;
    last_blank      = 0;
    awaited_partner = '0;
    cur_column      = 0;
    cand_column     = 0;
    cand_offset     = '0;
  endfunction

  // Returns 1 when the request writes a line table entry.
  function automatic bit index_step(input logic req, input logic [7:0] ch,
                                    output line_entry_t e);
    logic [31:0] off;
    bit          ends;
    bit          hit;
    int          idx;
    e = '0;
    if (req == wwli_pkg::REQ_START) begin
      clear_lines();
      lines_in_table = 1;
      e = make_entry(0, '0, 0);
      return 1;
    end
    if (lines_in_table == 0 || lines_in_table >= wwli_pkg::MAX_LINES) return 0;
    text_offset = text_offset + 32'd1;
    off = text_offset;
    if (awaited_partner != '0) begin
      hit = (ch == awaited_partner);
      awaited_partner = '0;
      if (hit) begin
        cand_offset = '0;
        e = make_entry(lines_in_table - 1, off, 1);
        return 1;
      end
    end
    if (ch == wwli_pkg::CHAR_TAB || ch == wwli_pkg::CHAR_SPACE) begin
      if (blank_run) return 0;
      blank_run = 1;
    end else begin
      blank_run = 0;
    end
    if (cur_column < 65535) cur_column++;
    if (!blank_run && last_blank) begin
      cand_column = cur_column - 1;
      cand_offset = off - 32'd1;
    end
    ends = (ch == wwli_pkg::CHAR_LF || ch == wwli_pkg::CHAR_CR);
    if (ends || (!blank_run && width_reg > 0 && cur_column > width_reg)) begin
      if (ends) begin
        awaited_partner = (ch == wwli_pkg::CHAR_LF) ? wwli_pkg::CHAR_CR : wwli_pkg::CHAR_LF;
        cand_column = cur_column;
        cand_offset = off;
      end else if (cand_offset == '0) begin
        cand_column = cur_column - 1;
        cand_offset = off - 32'd1;
      end
      idx = lines_in_table;
      lines_in_table++;
      e = make_entry(idx, cand_offset, 0);
      blank_run = 0;
      cur_column = (cand_column > cur_column) ? 0 : cur_column - cand_column;
      cand_column = 0;
      cand_offset = '0;
      last_blank = blank_run;
      return 1;
    end
    last_blank = blank_run;
    return 0;
  endfunction

  // Called at a falling edge; returns at a falling edge after the request is taken.
  task automatic send_req(input logic req, input logic [7:0] ch);
    line_entry_t e;
    while (idling && $urandom_range(0, 99) < 8) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = ch;
    s_tuser  = req;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (index_step(req, ch, e)) pending_entries.push_back(e);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(REQ_TEXT, s[i]);
  endtask

  task automatic start_text();
    send_req(wwli_pkg::REQ_START, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_entries.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_wrap_width(input logic [7:0] w);
    wait_drained();
    wrap_width_we    = 1'b1;
    wrap_width_wdata = w;
    @(negedge clk);
    wrap_width_we    = 1'b0;
    width_reg        = w;
  endtask

  always @(negedge clk) begin
    m_tready = !(idling && $urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_entries.size() == 0) begin
        $error("Unexpected line entry: tdata=%h tuser=%h", m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        entries_checked++;
        if (m_tdata[11:0] !== want.index) begin
          $error("entry_index: expected %0d, got %0d", want.index, m_tdata[11:0]);
          errors++;
        end
        if (m_tdata[43:12] !== want.offset) begin
          $error("entry_offset: expected %0d, got %0d", want.offset, m_tdata[43:12]);
          errors++;
        end
        if (m_tuser[0] !== want.rewrite) begin
          $error("is_rewrite: expected %0d, got %0d", want.rewrite, m_tuser[0]);
          errors++;
        end
        if (m_tdata[56:44] !== want.count) begin
          $error("line_count: expected %0d, got %0d", want.count, m_tdata[56:44]);
          errors++;
        end
        if (m_tdata[57] !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, m_tdata[57]);
          errors++;
        end
      end
    end
  end

  task automatic test_bytes_before_start();
    send_text("a");
    send_req(REQ_TEXT, wwli_pkg::CHAR_LF);
    wait_drained();
  endtask

  task automatic test_line_endings();
    write_wrap_width(8'd0);
    start_text();
    send_text("a");
    send_req(REQ_TEXT, wwli_pkg::CHAR_CR);
    send_req(REQ_TEXT, wwli_pkg::CHAR_LF);
    send_text("b");
    send_req(REQ_TEXT, wwli_pkg::CHAR_LF);
    send_req(REQ_TEXT, wwli_pkg::CHAR_CR);
    send_req(REQ_TEXT, wwli_pkg::CHAR_LF);
    send_req(REQ_TEXT, wwli_pkg::CHAR_LF);
    send_req(REQ_TEXT, wwli_pkg::CHAR_CR);
    send_req(REQ_TEXT, 8'h00);
    send_req(REQ_TEXT, 8'hFF);
    send_req(REQ_TEXT, wwli_pkg::CHAR_SPACE);
    send_req(REQ_TEXT, wwli_pkg::CHAR_TAB);
    send_text("d");
  endtask

  task automatic test_wrapping();
    write_wrap_width(8'd1);
    start_text();
    send_text("abc");
    write_wrap_width(8'd4);
    start_text();
    send_text("ab cde fghijk");
    write_wrap_width(8'd255);
    start_text();
    send_text("xy z");
  endtask

  task automatic test_random_text();
    logic [7:0] phase_width;
    int         r;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: phase_width = 8'd0;
        1: phase_width = 8'd1;
        2: phase_width = 8'd255;
        default: phase_width = 8'($urandom_range(2, 30));
      endcase
      idling = (phase != 3);
      write_wrap_width(phase_width);
      start_text();
      repeat (188) begin
        r = $urandom_range(0, 99);
        if (r < 3) start_text();
        else if (r < 8) send_req(REQ_TEXT, 8'($urandom_range(0, 255)));
        else if (r < 14) begin
          send_req(REQ_TEXT, $urandom_range(0, 1) ? wwli_pkg::CHAR_CR : wwli_pkg::CHAR_LF);
        end else if (r < 26) begin
          send_req(REQ_TEXT, $urandom_range(0, 1) ? wwli_pkg::CHAR_SPACE : wwli_pkg::CHAR_TAB);
        end else send_req(REQ_TEXT, 8'($urandom_range(8'h21, 8'h7E)));
      end
    end
    idling = 1;
  endtask

  initial begin
    rst              = 1'b1;
    wrap_width_we    = 1'b0;
    wrap_width_wdata = '0;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = '0;
    m_tready         = 1'b1;
    errors           = 0;
    requests_sent    = 0;
    entries_checked  = 0;
    idling           = 1;
    width_reg        = '0;
    clear_lines();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bytes_before_start();
    test_line_endings();
    test_wrapping();
    test_random_text();
    wait_drained();

    $display("Sent %0d requests and checked %0d line entries, covering CR/LF pairs,",
             requests_sent, entries_checked);
    $display("bytes before a start, blank runs and wrap widths 0 to 255 under random stalls.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
